[hdl/tasd_pkg.sv]
// Package for the tagged argument stream decoder.
// Holds the request/response payload types, command and kind codes, and queue sizes.
// No dependencies.
package tasd_pkg;

   // Request commands
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_DATA  = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // Result kinds
   localparam logic [3:0] KIND_INT32  = 4'd0;
   localparam logic [3:0] KIND_FLOAT  = 4'd1;
   localparam logic [3:0] KIND_STR    = 4'd2;
   localparam logic [3:0] KIND_BBYTE  = 4'd3;
   localparam logic [3:0] KIND_INT64  = 4'd4;
   localparam logic [3:0] KIND_TIME   = 4'd5;
   localparam logic [3:0] KIND_DOUBLE = 4'd6;
   localparam logic [3:0] KIND_CHAR   = 4'd7;
   localparam logic [3:0] KIND_TRUE   = 4'd8;
   localparam logic [3:0] KIND_FALSE  = 4'd9;
   localparam logic [3:0] KIND_NIL    = 4'd10;
   localparam logic [3:0] KIND_INF    = 4'd11;
   localparam logic [3:0] KIND_BLEN   = 4'd12;
   localparam logic [3:0] KIND_ERR    = 4'd13;

   // Error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_TAG   = 3'd1;
   localparam logic [2:0] ERR_SHORT_32  = 3'd2;
   localparam logic [2:0] ERR_SHORT_64  = 3'd3;
   localparam logic [2:0] ERR_NO_NUL    = 3'd4;
   localparam logic [2:0] ERR_BAD_BLOB  = 3'd5;

   // Seconds from 1900-01-01 to 1970-01-01: (70 * 365 + 17) days
   localparam logic [63:0] EPOCH_SHIFT = 64'd2208988800;

   // Queue sizes
   localparam int ITEM_DEPTH = 2;
   localparam int ITEM_PTR_W = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;
   localparam int ITEM_CNT_W = $clog2(ITEM_DEPTH + 1);
   localparam int RSP_DEPTH  = 2;
   localparam int RSP_PTR_W  = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   // What a start tag asks for
   typedef enum logic [2:0] {
      TOP_NOW    = 3'd0,
      TOP_FIXED  = 3'd1,
      TOP_STRING = 3'd2,
      TOP_BLOB   = 3'd3,
      TOP_BAD    = 3'd4
   } tag_op_type;

   // Decoder phases, one-hot
   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_FIXED  = 6'b000010,
      PH_STRING = 6'b000100,
      PH_BLEN   = 6'b001000,
      PH_BDATA  = 6'b010000,
      PH_PAD    = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] tag_char;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]         kind;
      logic signed [63:0] value;
      logic [31:0]        time_fraction;
      logic               immediate;
      logic               payload_valid;
      logic               last;
      logic [2:0]         error_code;
   } rsp_type;

   // Classified request passed from front to back
   typedef struct packed {
      logic [1:0] command;
      tag_op_type op;
      logic [3:0] kind;
      logic [7:0] data_byte;
   } item_type;

   // Handshake between front queue and back decoder
   typedef struct packed {
      logic valid;
      logic pop;
   } item_hs_type;

endpackage

[hdl/tasd_front.sv]
// Front end of the tagged argument stream decoder: classifies start tags
// and buffers classified requests in a short queue. Depends on tasd_pkg.
module tasd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  tasd_pkg::req_type req_item,
   output logic              item_valid,
   input  logic              item_pop,
   output tasd_pkg::item_type item_head
);

   tasd_pkg::item_type                 slot_ff [tasd_pkg::ITEM_DEPTH];
   logic [tasd_pkg::ITEM_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tasd_pkg::ITEM_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tasd_pkg::ITEM_CNT_W-1:0]    count_ff, count_in;
   tasd_pkg::item_type                 classified;
   logic                               push_ok;
   logic                               pop_ok;

   // Tag classification
   always_comb begin
      classified.command   = req_item.command;
      classified.data_byte = req_item.data_byte;
      classified.op        = tasd_pkg::TOP_BAD;
      classified.kind      = tasd_pkg::KIND_ERR;
      unique case (req_item.tag_char)
         8'h54: begin classified.op = tasd_pkg::TOP_NOW;    classified.kind = tasd_pkg::KIND_TRUE;   end // T
         8'h46: begin classified.op = tasd_pkg::TOP_NOW;    classified.kind = tasd_pkg::KIND_FALSE;  end // F
         8'h4E: begin classified.op = tasd_pkg::TOP_NOW;    classified.kind = tasd_pkg::KIND_NIL;    end // N
         8'h49: begin classified.op = tasd_pkg::TOP_NOW;    classified.kind = tasd_pkg::KIND_INF;    end // I
         8'h73: begin classified.op = tasd_pkg::TOP_STRING; classified.kind = tasd_pkg::KIND_STR;    end // s
         8'h62: begin classified.op = tasd_pkg::TOP_BLOB;   classified.kind = tasd_pkg::KIND_BLEN;   end // b
         8'h69: begin classified.op = tasd_pkg::TOP_FIXED;  classified.kind = tasd_pkg::KIND_INT32;  end // i
         8'h66: begin classified.op = tasd_pkg::TOP_FIXED;  classified.kind = tasd_pkg::KIND_FLOAT;  end // f
         8'h63: begin classified.op = tasd_pkg::TOP_FIXED;  classified.kind = tasd_pkg::KIND_CHAR;   end // c
         8'h68: begin classified.op = tasd_pkg::TOP_FIXED;  classified.kind = tasd_pkg::KIND_INT64;  end // h
         8'h74: begin classified.op = tasd_pkg::TOP_FIXED;  classified.kind = tasd_pkg::KIND_TIME;   end // t
         8'h64: begin classified.op = tasd_pkg::TOP_FIXED;  classified.kind = tasd_pkg::KIND_DOUBLE; end // d
         default: begin
            classified.op   = tasd_pkg::TOP_BAD;
            classified.kind = tasd_pkg::KIND_ERR;
         end
      endcase
   end

   // Queue control
   assign req_full   = (count_ff == tasd_pkg::ITEM_CNT_W'(tasd_pkg::ITEM_DEPTH));
   assign item_valid = (count_ff != '0);
   assign push_ok    = req_push & ~req_full;
   assign pop_ok     = item_pop & item_valid;
   assign item_head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == tasd_pkg::ITEM_PTR_W'(tasd_pkg::ITEM_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == tasd_pkg::ITEM_PTR_W'(tasd_pkg::ITEM_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ok && pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

[hdl/tasd_rsp_queue.sv]
// Result queue of the tagged argument stream decoder: holds finished results
// until the receiver pops them. Depends on tasd_pkg.
module tasd_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tasd_pkg::rsp_type wr_item,
   output logic              full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output tasd_pkg::rsp_type rsp_item
);

   tasd_pkg::rsp_type               slot_ff [tasd_pkg::RSP_DEPTH];
   logic [tasd_pkg::RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [tasd_pkg::RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [tasd_pkg::RSP_CNT_W-1:0]  count_ff, count_in;
   logic                            push_ok;
   logic                            pop_ok;

   assign full      = (count_ff == tasd_pkg::RSP_CNT_W'(tasd_pkg::RSP_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign push_ok   = push & ~full;
   assign pop_ok    = rsp_pop & ~rsp_empty;
   assign rsp_item  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == tasd_pkg::RSP_PTR_W'(tasd_pkg::RSP_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == tasd_pkg::RSP_PTR_W'(tasd_pkg::RSP_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ok && pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

[hdl/tasd_back.sv]
// Back end of the tagged argument stream decoder: runs the argument state
// machine on classified requests and builds results. Depends on tasd_pkg.
module tasd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tasd_pkg::item_hs_type item_hs_in,
   output logic                  item_pop,
   input  tasd_pkg::item_type    item,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output tasd_pkg::rsp_type     rsp_out
);

   tasd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          arg_kind_ff, arg_kind_in;
   logic [3:0]          byte_count_ff, byte_count_in;
   logic [63:0]         assembly_ff, assembly_in;
   logic [30:0]         blob_rem_ff, blob_rem_in;
   logic [1:0]          align_ff, align_in;

   logic                wide;
   logic [2:0]          pend_err;
   logic [63:0]         asm_shift;
   logic [31:0]         blen_word;
   logic [3:0]          cnt_inc;
   logic [1:0]          align_inc;
   logic [30:0]         rem_dec;
   logic [63:0]         unix_secs;
   logic                res_valid;
   tasd_pkg::rsp_type   res;

   // Take a request whenever one waits and the result queue has room
   assign item_pop = item_hs_in.valid & ~rsp_full;
   assign rsp_push = item_pop & res_valid;
   assign rsp_out  = res;

   assign wide = (arg_kind_ff == tasd_pkg::KIND_INT64) ||
                 (arg_kind_ff == tasd_pkg::KIND_TIME) ||
                 (arg_kind_ff == tasd_pkg::KIND_DOUBLE);

   // Error an unfinished argument reports on start or end
   always_comb begin
      unique case (phase_ff)
         tasd_pkg::PH_FIXED:  pend_err = wide ? tasd_pkg::ERR_SHORT_64 : tasd_pkg::ERR_SHORT_32;
         tasd_pkg::PH_STRING: pend_err = tasd_pkg::ERR_NO_NUL;
         tasd_pkg::PH_BLEN:   pend_err = tasd_pkg::ERR_SHORT_32;
         tasd_pkg::PH_BDATA:  pend_err = tasd_pkg::ERR_BAD_BLOB;
         default:             pend_err = tasd_pkg::ERR_NONE;
      endcase
   end

   // Datapath helpers
   assign asm_shift = {assembly_ff[55:0], item.data_byte};
   assign blen_word = {assembly_ff[23:0], item.data_byte};
   assign cnt_inc   = byte_count_ff + 4'd1;
   assign align_inc = align_ff + 2'd1;
   assign rem_dec   = blob_rem_ff - 31'd1;
   assign unix_secs = {32'd0, asm_shift[63:32]} - tasd_pkg::EPOCH_SHIFT;

   // Argument state machine
   always_comb begin
      phase_in      = phase_ff;
      arg_kind_in   = arg_kind_ff;
      byte_count_in = byte_count_ff;
      assembly_in   = assembly_ff;
      blob_rem_in   = blob_rem_ff;
      align_in      = align_ff;
      res_valid     = 1'b0;
      res           = '0;

      if (item_pop) begin
         unique case (item.command)
            tasd_pkg::CMD_START: begin
               phase_in      = tasd_pkg::PH_IDLE;
               byte_count_in = '0;
               assembly_in   = '0;
               blob_rem_in   = '0;
               align_in      = '0;
               if (pend_err != tasd_pkg::ERR_NONE) begin
                  res_valid      = 1'b1;
                  res.kind       = tasd_pkg::KIND_ERR;
                  res.error_code = pend_err;
               end else begin
                  unique case (item.op)
                     tasd_pkg::TOP_NOW: begin
                        res_valid         = 1'b1;
                        res.kind          = item.kind;
                        res.value         = (item.kind == tasd_pkg::KIND_TRUE) ? 64'sd1 : 64'sd0;
                        res.payload_valid = 1'b1;
                     end
                     tasd_pkg::TOP_FIXED, tasd_pkg::TOP_STRING, tasd_pkg::TOP_BLOB: begin
                        arg_kind_in = item.kind;
                        unique case (item.op)
                           tasd_pkg::TOP_STRING: phase_in = tasd_pkg::PH_STRING;
                           tasd_pkg::TOP_BLOB:   phase_in = tasd_pkg::PH_BLEN;
                           default:              phase_in = tasd_pkg::PH_FIXED;
                        endcase
                     end
                     default: begin
                        res_valid      = 1'b1;
                        res.kind       = tasd_pkg::KIND_ERR;
                        res.error_code = tasd_pkg::ERR_BAD_TAG;
                     end
                  endcase
               end
            end

            tasd_pkg::CMD_END: begin
               phase_in      = tasd_pkg::PH_IDLE;
               byte_count_in = '0;
               assembly_in   = '0;
               blob_rem_in   = '0;
               align_in      = '0;
               if (pend_err != tasd_pkg::ERR_NONE) begin
                  res_valid      = 1'b1;
                  res.kind       = tasd_pkg::KIND_ERR;
                  res.error_code = pend_err;
               end
            end

            tasd_pkg::CMD_DATA: begin
               unique case (phase_ff)
                  // Big-endian assembly of 4- or 8-byte values
                  tasd_pkg::PH_FIXED: begin
                     assembly_in   = asm_shift;
                     byte_count_in = cnt_inc;
                     if (cnt_inc >= (wide ? 4'd8 : 4'd4)) begin
                        res_valid         = 1'b1;
                        res.kind          = arg_kind_ff;
                        res.payload_valid = 1'b1;
                        case (arg_kind_ff)
                           tasd_pkg::KIND_INT32:
                              res.value = {{32{asm_shift[31]}}, asm_shift[31:0]};
                           tasd_pkg::KIND_FLOAT:
                              res.value = {32'd0, asm_shift[31:0]};
                           tasd_pkg::KIND_CHAR:
                              res.value = {56'd0, asm_shift[7:0]};
                           tasd_pkg::KIND_TIME: begin
                              if (asm_shift == 64'd1) begin
                                 res.immediate = 1'b1;
                              end else begin
                                 res.value         = unix_secs;
                                 res.time_fraction = asm_shift[31:0];
                              end
                           end
                           default:
                              res.value = asm_shift;
                        endcase
                        phase_in      = tasd_pkg::PH_IDLE;
                        byte_count_in = '0;
                        assembly_in   = '0;
                        blob_rem_in   = '0;
                        align_in      = '0;
                     end
                  end

                  // String characters, NUL ends the run
                  tasd_pkg::PH_STRING: begin
                     align_in  = align_inc;
                     res_valid = 1'b1;
                     res.kind  = tasd_pkg::KIND_STR;
                     if (item.data_byte != 8'd0) begin
                        res.value         = {56'd0, item.data_byte};
                        res.payload_valid = 1'b1;
                     end else begin
                        res.last      = 1'b1;
                        phase_in      = (align_inc == 2'd0) ? tasd_pkg::PH_IDLE : tasd_pkg::PH_PAD;
                        byte_count_in = '0;
                        assembly_in   = '0;
                        blob_rem_in   = '0;
                     end
                  end

                  // Blob length header
                  tasd_pkg::PH_BLEN: begin
                     assembly_in   = {32'd0, blen_word};
                     byte_count_in = cnt_inc;
                     if (cnt_inc >= 4'd4) begin
                        res_valid     = 1'b1;
                        phase_in      = tasd_pkg::PH_IDLE;
                        byte_count_in = '0;
                        assembly_in   = '0;
                        blob_rem_in   = '0;
                        align_in      = '0;
                        if (blen_word[31]) begin
                           res.kind       = tasd_pkg::KIND_ERR;
                           res.error_code = tasd_pkg::ERR_BAD_BLOB;
                        end else begin
                           res.kind          = tasd_pkg::KIND_BLEN;
                           res.value         = {33'd0, blen_word[30:0]};
                           res.payload_valid = 1'b1;
                           res.last          = (blen_word[30:0] == 31'd0);
                           if (blen_word[30:0] != 31'd0) begin
                              phase_in    = tasd_pkg::PH_BDATA;
                              arg_kind_in = tasd_pkg::KIND_BBYTE;
                              blob_rem_in = blen_word[30:0];
                           end
                        end
                     end
                  end

                  // Blob bytes
                  tasd_pkg::PH_BDATA: begin
                     align_in          = align_inc;
                     blob_rem_in       = rem_dec;
                     res_valid         = 1'b1;
                     res.kind          = tasd_pkg::KIND_BBYTE;
                     res.value         = {56'd0, item.data_byte};
                     res.payload_valid = 1'b1;
                     if (rem_dec == 31'd0) begin
                        res.last      = 1'b1;
                        phase_in      = (align_inc == 2'd0) ? tasd_pkg::PH_IDLE : tasd_pkg::PH_PAD;
                        byte_count_in = '0;
                        assembly_in   = '0;
                     end
                  end

                  // Skip padding to a 4-byte boundary
                  tasd_pkg::PH_PAD: begin
                     align_in = align_inc;
                     if (align_inc == 2'd0) begin
                        phase_in      = tasd_pkg::PH_IDLE;
                        byte_count_in = '0;
                        assembly_in   = '0;
                        blob_rem_in   = '0;
                     end
                  end

                  default: begin
                     // idle: data is dropped
                  end
               endcase
            end

            default: begin
               // unused command: no effect
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= tasd_pkg::PH_IDLE;
         arg_kind_ff   <= '0;
         byte_count_ff <= '0;
         assembly_ff   <= '0;
         blob_rem_ff   <= '0;
         align_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         arg_kind_ff   <= arg_kind_in;
         byte_count_ff <= byte_count_in;
         assembly_ff   <= assembly_in;
         blob_rem_ff   <= blob_rem_in;
         align_ff      <= align_in;
      end
   end

`ifndef SYNTHESIS
   // Blob counter only live while blob bytes are expected
   a_blob_rem_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != tasd_pkg::PH_BDATA) |-> (blob_rem_ff == 31'd0))
      else $error("blob counter nonzero outside blob data");

   // Alignment counter cleared whenever idle
   a_align_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tasd_pkg::PH_IDLE) |-> (align_ff == 2'd0))
      else $error("alignment counter nonzero while idle");

   // Fourth byte of a narrow value completes it and returns to idle
   a_narrow_done: assert property (@(posedge clock) disable iff (reset)
      (item_pop && item.command == tasd_pkg::CMD_DATA &&
       phase_ff == tasd_pkg::PH_FIXED && byte_count_ff == 4'd3 && !wide)
      |=> (phase_ff == tasd_pkg::PH_IDLE))
      else $error("narrow value not completed after four bytes");

   // Never push a result into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");
`endif

endmodule

[hdl/tagged_argument_stream_decoder_unit.sv]
// Top level of the tagged argument stream decoder.
// Instantiates tasd_front, tasd_back and tasd_rsp_queue; depends on tasd_pkg.
//
// Usage:
//   Request channel: drive req_item and raise req_push; the request is taken
//   at a rising edge where req_push is high and req_full is low. A start
//   request carries a type tag, a data request one argument byte, an end
//   request closes the packet data.
//   Result channel: while rsp_empty is low the oldest result sits on
//   rsp_item; it is taken at an edge where rsp_pop is high.
//   Path: a taken request waits in the request queue, is decoded as it
//   leaves, and its result (if any) is registered in the result queue.
//   Throughput: one request per cycle while the result queue has room, set
//   by the decoder state machine, handling one classified request each cycle.
//   Stall: results wait in a two-entry queue; once it fills the decoder
//   holds, the two-entry request queue then fills and req_full rises.
//   Reset: synchronous, active high; both queues empty and the decoder
//   returns to idle with all counters and the assembly register cleared.
module tagged_argument_stream_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  tasd_pkg::req_type req_item,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output tasd_pkg::rsp_type rsp_item
);

   tasd_pkg::item_hs_type item_hs;
   tasd_pkg::item_type    item_head;
   logic                  item_valid;
   logic                  item_pop;
   logic                  rsp_full;
   logic                  rsp_push;
   tasd_pkg::rsp_type     rsp_new;

   // Front: classify and queue requests
   tasd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item_head  (item_head)
   );

   always_comb begin
      item_hs.valid = item_valid;
      item_hs.pop   = item_pop;
   end

   // Back: argument decoding
   tasd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_hs_in (item_hs),
      .item_pop   (item_pop),
      .item       (item_head),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_out    (rsp_new)
   );

   // Result queue
   tasd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .wr_item   (rsp_new),
      .full      (rsp_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
